// ===== rtl/bounded_double_ended_queue_core_macros.svh =====
// assertion macros for the double-ended queue checker
// no dependencies; included by the checker file only
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// same-cycle implication under async active-low reset
`define BDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("bdq assertion failed");

// next-cycle implication under async active-low reset
`define BDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("bdq assertion failed");

`endif

// ===== rtl/bdq_pkg.sv =====
// shared constants, types and helper functions of the double-ended queue
// no dependencies
package bdq_pkg;

	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;

	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ACTION_W = 3;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 8;
	localparam int STATUS_W = 2;
	localparam int LENGTH_W = 5;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 40;

	// operation codes (action >> 1)
	localparam logic [1:0] OP_PUT = 2'd0;
	localparam logic [1:0] OP_GET = 2'd1;
	localparam logic [1:0] OP_ITH = 2'd2;
	localparam logic [1:0] OP_REM = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic  we;
		slot_t waddr;
		word_t wdata;
		slot_t raddr;
	} mem_req_t;

	typedef struct packed {
		logic                 valid;
		logic [VALUE_W-1:0]   word;
		logic [STATUS_W-1:0]  status;
		logic [LENGTH_W-1:0]  length;
	} result_t;

	// ring slot of position pos from base, both below capacity
	function automatic slot_t slot_add(slot_t base, cnt_t pos);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(base) + (CNT_W + 1)'(pos);
		if (s >= (CNT_W + 1)'(CAPACITY))
			s = s - (CNT_W + 1)'(CAPACITY);
		return s[SLOT_W-1:0];
	endfunction

	function automatic slot_t slot_dec(slot_t base);
		return (base == '0) ? SLOT_W'(CAPACITY - 1) : base - SLOT_W'(1);
	endfunction

	// position from the head of the word pos places in from the chosen end
	function automatic cnt_t from_head(logic tail, cnt_t count, cnt_t pos);
		return tail ? (count - cnt_t'(1) - pos) : pos;
	endfunction

	function automatic word_t to_word(logic [VALUE_W-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[WORD_BITS-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] from_word(word_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[VALUE_W-1:0];
	endfunction

endpackage

// ===== rtl/bdq_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bdq_seq.sv =====
// request sequencer: ring pointers, scan and shift over the ring store
// depends on bdq_pkg
module bdq_seq
	import bdq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACTION_W-1:0] action,
	input  word_t               value,
	input  logic [INDEX_W-1:0]  index,
	input  logic                out_free,
	input  word_t               rdata,
	output mem_req_t            mem,
	output result_t             res
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam int IDX_CMP_W = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

	logic [2:0]          state_q, state_d;
	slot_t               head_q, head_d;
	cnt_t                count_q, count_d;
	cnt_t                k_q, k_d;
	word_t               word_q, word_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [ACTION_W-1:0] act_q;
	word_t               value_q;
	logic [INDEX_W-1:0]  index_q;

	logic       tail;
	logic [1:0] op;
	cnt_t       pos;

	assign tail     = act_q[0];
	assign op       = act_q[2:1];
	assign in_ready = (state_q == S_IDLE);
	assign pos      = from_head(tail, count_q, k_q);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		k_d       = k_q;
		word_d    = word_q;
		status_d  = status_q;
		mem.we    = 1'b0;
		mem.waddr = head_q;
		mem.wdata = value_q;
		mem.raddr = head_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_START;
			end
			S_START: begin
				word_d   = '0;
				status_d = ST_OK;
				case (op)
					OP_PUT: begin
						state_d = S_DONE;
						if (count_q == cnt_t'(CAPACITY)) begin
							status_d = ST_FULL;
						end else begin
							mem.we  = 1'b1;
							count_d = count_q + cnt_t'(1);
							if (tail) begin
								mem.waddr = slot_add(head_q, count_q);
							end else begin
								mem.waddr = slot_dec(head_q);
								head_d    = slot_dec(head_q);
							end
						end
					end
					OP_GET: begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_DONE;
						end else begin
							mem.raddr = tail ? slot_add(head_q, count_q - cnt_t'(1)) : head_q;
							state_d   = S_WAIT;
						end
					end
					OP_ITH: begin
						if (IDX_CMP_W'(index_q) >= IDX_CMP_W'(count_q)) begin
							status_d = ST_RANGE;
							state_d  = S_DONE;
						end else begin
							mem.raddr = slot_add(head_q,
								from_head(tail, count_q, cnt_t'(index_q)));
							state_d   = S_WAIT;
						end
					end
					default: begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_DONE;
						end else begin
							k_d       = '0;
							mem.raddr = slot_add(head_q, from_head(tail, count_q, '0));
							state_d   = S_SCAN;
						end
					end
				endcase
			end
			S_WAIT: begin
				word_d  = rdata;
				state_d = S_DONE;
				if (op == OP_GET) begin
					count_d = count_q - cnt_t'(1);
					if (!tail)
						head_d = slot_add(head_q, cnt_t'(1));
				end
			end
			S_SCAN: begin
				// compare word k while the read of word k+1 is already issued
				if (rdata == value_q) begin
					word_d   = value_q;
					status_d = ST_OK;
					if (pos + cnt_t'(1) < count_q) begin
						k_d       = pos;
						mem.raddr = slot_add(head_q, pos + cnt_t'(1));
						state_d   = S_SHIFT;
					end else begin
						count_d = count_q - cnt_t'(1);
						state_d = S_DONE;
					end
				end else if (k_q + cnt_t'(1) < count_q) begin
					k_d       = k_q + cnt_t'(1);
					mem.raddr = slot_add(head_q, from_head(tail, count_q, k_q + cnt_t'(1)));
				end else begin
					status_d = ST_EMPTY;
					word_d   = '0;
					state_d  = S_DONE;
				end
			end
			S_SHIFT: begin
				// move word k+1 down to slot k; read of k+2 runs alongside
				mem.we    = 1'b1;
				mem.waddr = slot_add(head_q, k_q);
				mem.wdata = rdata;
				if (k_q + cnt_t'(2) < count_q) begin
					k_d       = k_q + cnt_t'(1);
					mem.raddr = slot_add(head_q, k_q + cnt_t'(2));
				end else begin
					count_d = count_q - cnt_t'(1);
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		res.valid  = (state_q == S_DONE);
		res.word   = from_word(word_q);
		res.status = status_q;
		res.length = LENGTH_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q      <= k_d;
		word_q   <= word_d;
		status_q <= status_d;
		if (in_valid && in_ready) begin
			act_q   <= action;
			value_q <= value;
			index_q <= index;
		end
	end

endmodule

// ===== rtl/bounded_double_ended_queue_core.sv =====
// sequencer steps per request: put, get on empty, ith out of range and rem on empty go
// from start to done; get and ith add a ram read wait; rem scans from the chosen end, then on
// a hit shifts the later words down (one ram read per scanned word, one per shifted word)
// one request in work at a time, next request taken once back in idle after the result
// is registered; rem takes longest, its reads and writes sharing the single ring store ports
// a new request is taken while the previous result waits in the output register
// arst_n clears head slot, length and handshake state; the ring store is not cleared
module bounded_double_ended_queue_core
	import bdq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// request stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // action[2:0], value[34:3], index[42:35], zero pad
	// result stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // result_word[31:0], status[33:32], length[38:34], pad
);

	// request fields unpacked from the stream word
	logic [ACTION_W-1:0] action;
	logic [VALUE_W-1:0]  value;
	logic [INDEX_W-1:0]  index;

	assign action = s_tdata[ACTION_W-1:0];
	assign value  = s_tdata[ACTION_W +: VALUE_W];
	assign index  = s_tdata[ACTION_W + VALUE_W +: INDEX_W];

	mem_req_t mem;
	word_t    rdata;
	result_t  res;

	logic             m_valid_q;
	logic [OUT_W-1:0] m_data_q;
	logic             out_free;

	// output register can take a result when empty or being drained
	assign out_free = !m_valid_q || m_tready;

	// ring store: one write and one registered read per cycle
	bdq_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (CAPACITY)
	) u_ring (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	// pointer keeping, scan and gap-closing sequencer
	bdq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.action   (action),
		.value    (to_word(value)),
		.index    (index),
		.out_free (out_free),
		.rdata    (rdata),
		.mem      (mem),
		.res      (res)
	);

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid)
			m_data_q <= OUT_W'({res.length, res.status, res.word});
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== rtl/bdq_checker.sv =====
// port-level checker for the double-ended queue, bound to the top level
// depends on bdq_pkg and bounded_double_ended_queue_core_macros.svh
`include "bounded_double_ended_queue_core_macros.svh"

module bdq_checker
	import bdq_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	logic [VALUE_W-1:0]  r_word;
	logic [STATUS_W-1:0] r_status;
	logic [LENGTH_W-1:0] r_length;

	assign r_word   = m_tdata[VALUE_W-1:0];
	assign r_status = m_tdata[VALUE_W +: STATUS_W];
	assign r_length = m_tdata[VALUE_W + STATUS_W +: LENGTH_W];

	// a waiting request holds
	`BDQ_ASSERT_NXT(a_req_hold, clk, arst_n, s_tvalid && !s_tready,
		s_tvalid && $stable(s_tdata))
	// a stalled result holds
	`BDQ_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// length never passes capacity
	`BDQ_ASSERT_IMP(a_len, clk, arst_n, m_tvalid, r_length <= LENGTH_W'(CAPACITY))
	// full is reported only with the queue at capacity
	`BDQ_ASSERT_IMP(a_full, clk, arst_n, m_tvalid && r_status == ST_FULL,
		r_length == LENGTH_W'(CAPACITY))
	// failed requests return a zero word
	`BDQ_ASSERT_IMP(a_zero, clk, arst_n, m_tvalid && r_status != ST_OK, r_word == '0)

endmodule

bind bounded_double_ended_queue_core bdq_checker u_bdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/bounded_double_ended_queue_core_tb.sv =====
// self-checking testbench for the bounded double-ended queue core
// depends on bdq_pkg and bounded_double_ended_queue_core; mirrors the ring in plain sv
`timescale 1ns / 1ps

module bounded_double_ended_queue_core_tb;
	import bdq_pkg::*;

	// requests as they appear in the action field: op in bits 2:1, tail end in bit 0
	typedef enum logic [ACTION_W-1:0] {
		HEAD_PUT = 3'd0,
		TAIL_PUT = 3'd1,
		HEAD_GET = 3'd2,
		TAIL_GET = 3'd3,
		HEAD_ITH = 3'd4,
		TAIL_ITH = 3'd5,
		HEAD_REM = 3'd6,
		TAIL_REM = 3'd7
	} action_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  word;
		logic [STATUS_W-1:0] status;
		logic [LENGTH_W-1:0] count_after;
	} deque_result_t;

	// drain wait after the last result, sized from the longest rem with margin
	localparam int DRAIN_CYCLES = 1 + 2 * CAPACITY + 20;
	localparam int CYCLE_LIMIT  = 200000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	// mirror of the queue contents, updated when a request is accepted
	word_t mirror_slots [CAPACITY];
	int    mirror_head = 0;
	int    mirror_count = 0;

	deque_result_t      pending_results [$];
	logic [VALUE_W-1:0] value_pool [8];
	int                 mismatches = 0;
	int                 cycle_count = 0;
	logic               stalls_on = 1'b1;

	bounded_double_ended_queue_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// applies one request to the mirror and returns the result it must produce
	function automatic deque_result_t mirror_request(action_t act, logic [VALUE_W-1:0] v,
			logic [INDEX_W-1:0] idx);
		deque_result_t r;
		logic          tail;
		int            pos;
		int            k;
		int            j;
		tail = act[0];
		r.word = '0;
		r.status = ST_OK;
		case (act[2:1])
			OP_PUT: begin
				if (mirror_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (tail) begin
					mirror_slots[(mirror_head + mirror_count) % CAPACITY] = v;
					mirror_count++;
				end else begin
					mirror_head = (mirror_head + CAPACITY - 1) % CAPACITY;
					mirror_slots[mirror_head] = v;
					mirror_count++;
				end
			end
			OP_GET: begin
				if (mirror_count == 0) begin
					r.status = ST_EMPTY;
				end else if (tail) begin
					r.word = mirror_slots[(mirror_head + mirror_count - 1) % CAPACITY];
					mirror_count--;
				end else begin
					r.word = mirror_slots[mirror_head];
					mirror_head = (mirror_head + 1) % CAPACITY;
					mirror_count--;
				end
			end
			OP_ITH: begin
				if (int'(idx) >= mirror_count) begin
					r.status = ST_RANGE;
				end else begin
					pos = tail ? mirror_count - 1 - int'(idx) : int'(idx);
					r.word = mirror_slots[(mirror_head + pos) % CAPACITY];
				end
			end
			default: begin
				// search from the chosen end, nearest match wins, later words close the gap
				r.status = ST_EMPTY;
				for (k = 0; k < mirror_count && r.status != ST_OK; k++) begin
					pos = tail ? mirror_count - 1 - k : k;
					if (mirror_slots[(mirror_head + pos) % CAPACITY] == v) begin
						r.word = v;
						r.status = ST_OK;
						for (j = pos; j + 1 < mirror_count; j++)
							mirror_slots[(mirror_head + j) % CAPACITY] =
								mirror_slots[(mirror_head + j + 1) % CAPACITY];
						mirror_count--;
					end
				end
			end
		endcase
		r.count_after = LENGTH_W'(mirror_count);
		return r;
	endfunction

	// drives one request from a falling edge and returns at the falling edge after acceptance
	task automatic send_request(action_t act, logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] idx);
		while (stalls_on && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {(IN_W - ACTION_W - VALUE_W - INDEX_W)'(0), idx, v, act};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(mirror_request(act, v, idx));
		@(negedge clk);
	endtask

	task automatic note_mismatch(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %h, got %h", field, want, got);
	endtask

	// receiver side: ready drops in about a third of the cycles while stalls are on
	always @(negedge clk) begin
		m_tready <= !stalls_on || ($urandom_range(99) >= 34);
	end

	// result checker, sampled at the rising edge
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result with no request pending", '0, m_tdata[VALUE_W-1:0]);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[VALUE_W-1:0] !== want.word)
					note_mismatch("result_word", want.word, m_tdata[VALUE_W-1:0]);
				if (m_tdata[VALUE_W+STATUS_W-1:VALUE_W] !== want.status)
					note_mismatch("status", VALUE_W'(want.status),
						VALUE_W'(m_tdata[VALUE_W+STATUS_W-1:VALUE_W]));
				if (m_tdata[VALUE_W+STATUS_W+LENGTH_W-1:VALUE_W+STATUS_W] !== want.count_after)
					note_mismatch("length", VALUE_W'(want.count_after),
						VALUE_W'(m_tdata[VALUE_W+STATUS_W+LENGTH_W-1:VALUE_W+STATUS_W]));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// get, ith and rem on an empty queue
	task automatic test_empty_queue();
		send_request(HEAD_GET, 32'h0, 8'd0);
		send_request(TAIL_ITH, 32'h0, 8'd255);
		send_request(HEAD_REM, 32'hFFFF_FFFF, 8'd0);
	endtask

	// fill from both ends with edge words and a duplicate, then overflow
	task automatic test_fill_and_overflow();
		logic [VALUE_W-1:0] v;
		for (int i = 0; i < CAPACITY; i++) begin
			if (i == 0)
				v = '0;
			else if (i == 1 || i == 6)
				v = 32'hFFFF_FFFF;
			else
				v = $urandom;
			send_request(i[0] ? TAIL_PUT : HEAD_PUT, v, 8'($urandom));
		end
		send_request(TAIL_PUT, 32'h5A5A_A5A5, 8'd0);
	endtask

	// reads at the index bounds, removes of a zero word, a duplicate and a missing word, then a get at each end
	task automatic test_search_and_read();
		send_request(HEAD_ITH, 32'h0, 8'(CAPACITY - 1));
		send_request(TAIL_ITH, 32'h0, 8'(CAPACITY));
		send_request(HEAD_REM, 32'h0, 8'd0);
		send_request(TAIL_REM, 32'hFFFF_FFFF, 8'd0);
		send_request(TAIL_REM, 32'hA5A5_5A5A, 8'd0);
		send_request(TAIL_GET, 32'h0, 8'd0);
		send_request(HEAD_GET, 32'h0, 8'd0);
	endtask

	// random requests; the mix swings between filling and draining so every length is seen
	task automatic test_random_traffic(int n);
		action_t            act;
		logic [VALUE_W-1:0] v;
		logic [INDEX_W-1:0] idx;
		logic [1:0]         op;
		int                 r;
		logic               filling;
		int                 phase_left;
		filling = 1'b1;
		phase_left = $urandom_range(10, 40);
		for (int i = 0; i < n; i++) begin
			if (phase_left == 0) begin
				filling = !filling;
				phase_left = $urandom_range(10, 40);
			end
			phase_left--;
			r = $urandom_range(99);
			if (filling)
				op = (r < 50) ? OP_PUT : (r < 65) ? OP_GET : (r < 82) ? OP_ITH : OP_REM;
			else
				op = (r < 20) ? OP_PUT : (r < 60) ? OP_GET : (r < 80) ? OP_ITH : OP_REM;
			act = action_t'({op, 1'($urandom_range(1))});
			// repeated words from a small pool make rem hits and direction matter
			if ($urandom_range(99) < 40)
				v = value_pool[$urandom_range(7)];
			else
				v = $urandom;
			if (op == OP_REM && mirror_count > 0 && $urandom_range(99) < 60)
				v = mirror_slots[(mirror_head + $urandom_range(mirror_count - 1)) % CAPACITY];
			if (op == OP_ITH && $urandom_range(99) < 80)
				idx = INDEX_W'($urandom_range(CAPACITY + 1));
			else
				idx = INDEX_W'($urandom);
			send_request(act, v, idx);
		end
	endtask

	// sender holds off until every outstanding request has its result
	task automatic test_drain_pause();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		value_pool[0] = '0;
		value_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 8; i++)
			value_pool[i] = $urandom;
		for (int i = 0; i < CAPACITY; i++)
			mirror_slots[i] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_queue();
		test_fill_and_overflow();
		test_search_and_read();
		test_random_traffic(250);
		test_drain_pause();
		// stretch with both sides always ready
		stalls_on = 1'b0;
		test_random_traffic(120);
		stalls_on = 1'b1;
		test_random_traffic(255);

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
